// File: design/stt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer table package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stt_pkg;

   // table geometry
   localparam int SLOTS       = 16;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int HANDLE_W    = 16;
   localparam int TICK_W      = 36;
   localparam int SEC_W       = 32;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   // period conversion: secs * (USECS_PER_SEC / TICK_USECS) + usecs / TICK_USECS
   localparam int TICK_USECS    = 100000;
   localparam int USECS_PER_SEC = 1000000;
   localparam int SECS_TICKS    = USECS_PER_SEC / TICK_USECS;
   // TICK_USECS = 2^5 * 3125: shift out the power of two, then multiply by
   // ceil(2^39 / 3125), exact for every 27-bit dividend
   localparam int UX_SHIFT      = 5;
   localparam int UX_W          = SEC_W - UX_SHIFT;
   localparam int RECIP_W       = 28;
   localparam logic [RECIP_W-1:0] RECIP_M = 28'd175921861;
   localparam int RECIP_SHIFT   = 39;
   localparam int PROD_W        = UX_W + RECIP_W;
   localparam int CONV_STEPS    = 2;
   localparam int STEP_W        = 2;

   // stream payload widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_CANCEL = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RM,
      ST_ADD_WAIT,
      ST_CANCEL,
      ST_QUERY,
      ST_TICK,
      ST_REINS
   } state_type;

   typedef enum logic [2:0] {
      TOP_NONE,
      TOP_REMOVE_MATCH,
      TOP_INSERT_NEW,
      TOP_FIRE_HEAD,
      TOP_INSERT_FIRED,
      TOP_TICK_DONE
   } table_op_type;

   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_ADD,
      PUSH_CANCEL,
      PUSH_QUERY
   } push_type;

   typedef struct packed {
      logic         capture;
      table_op_type op;
      push_type     push;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic head_fire;
      logic fire_report;
      logic pend_valid;
   } status_type;

endpackage

// File: design/sorted_timer_table_unit.sv
// Sequence: a cancel or query result is loaded into the output register after
//   its request is taken, an add result after the period conversion, a tick
//   result after every expiring entry has fired, plus any wait on the result channel.
// Throughput: one transaction at a time; the next request is taken the cycle
//   after the last result is loaded into the output register.
// Reset: synchronous, clears the table and all control state.
// ----------------------------------------------------------------------------
// Sorted timer table unit
// Timer slots kept in order of remaining ticks; add, cancel, query and tick.
// ----------------------------------------------------------------------------
module sorted_timer_table_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // handle[15:0], periodic[16], secs[48:17], usecs[80:49]
   input  logic [stt_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // fired_valid[0], fired_handle[16:1], is_active[17], removed_count[18],
   // status[19]
   output logic [stt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import stt_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic               conv_done;
   logic [TICK_W-1:0]  conv_ticks;
   action_type         req_action;

   assign req_action = action_type'(req_tuser);

   stt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_action),
      .conv_done  (conv_done),
      .status     (status),
      .cmd        (cmd)
   );

   stt_tick_conv u_conv (
      .clock (clock),
      .reset (reset),
      .load  (cmd.capture),
      .secs  (req_tdata[48:17]),
      .usecs (req_tdata[80:49]),
      .done  (conv_done),
      .ticks (conv_ticks)
   );

   stt_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_handle   (req_tdata[15:0]),
      .req_periodic (req_tdata[16]),
      .conv_ticks   (conv_ticks),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

// File: design/stt_tick_conv.sv
// ----------------------------------------------------------------------------
// Period to tick converter
// Ticks are seconds times ten plus microseconds over the tick length, the
// quotient taken by reciprocal multiplication, registered, then added in.
// ----------------------------------------------------------------------------
module stt_tick_conv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [stt_pkg::SEC_W-1:0]  secs,
   input  logic [stt_pkg::SEC_W-1:0]  usecs,
   output logic                       done,
   output logic [stt_pkg::TICK_W-1:0] ticks
);
   import stt_pkg::*;

   logic [SEC_W-1:0]  secs_ff, secs_in;
   logic [UX_W-1:0]   ux_ff, ux_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [TICK_W-1:0] tens_ff, tens_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;

   // capture, multiply, then add the two parts
   always_comb begin
      secs_in  = secs_ff;
      ux_in    = ux_ff;
      prod_in  = prod_ff;
      tens_in  = tens_ff;
      ticks_in = ticks_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      if (load) begin
         secs_in = secs;
         ux_in   = usecs[SEC_W-1:UX_SHIFT];
         step_in = STEP_W'(CONV_STEPS);
         run_in  = 1'b1;
      end else if (run_ff && step_ff == STEP_W'(2)) begin
         prod_in = PROD_W'(ux_ff) * PROD_W'(RECIP_M);
         tens_in = TICK_W'(secs_ff) * TICK_W'(SECS_TICKS);
         step_in = step_ff - 1'b1;
      end else if (run_ff && step_ff == STEP_W'(1)) begin
         ticks_in = tens_ff + TICK_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
         step_in  = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      secs_ff  <= secs_in;
      ux_ff    <= ux_in;
      prod_ff  <= prod_in;
      tens_ff  <= tens_in;
      ticks_ff <= ticks_in;
   end

   // the largest period stays below 2^36 ticks
   assign done  = run_ff && (step_ff == '0);
   assign ticks = ticks_ff;

endmodule

// File: design/stt_datapath.sv
// ----------------------------------------------------------------------------
// Sorted timer table datapath
// Slot registers in list order, match and insert-position search, the
// pending firing and the result output register.
// ----------------------------------------------------------------------------
module stt_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  stt_pkg::cmd_type             cmd,
   output stt_pkg::status_type          status,
   input  logic [stt_pkg::HANDLE_W-1:0] req_handle,
   input  logic                         req_periodic,
   input  logic [stt_pkg::TICK_W-1:0]   conv_ticks,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [stt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                         rsp_tlast
);
   import stt_pkg::*;

   // slot storage
   logic                used_ff [SLOTS], used_in [SLOTS];
   logic                seen_ff [SLOTS], seen_in [SLOTS];
   logic [HANDLE_W-1:0] hnd_ff  [SLOTS], hnd_in  [SLOTS];
   logic [TICK_W-1:0]   tck_ff  [SLOTS], tck_in  [SLOTS];
   logic [TICK_W-1:0]   rld_ff  [SLOTS], rld_in  [SLOTS];
   logic                per_ff  [SLOTS], per_in  [SLOTS];

   // current transaction and fired entry
   logic [HANDLE_W-1:0] cur_hnd_ff;
   logic                cur_per_ff;
   logic [HANDLE_W-1:0] fire_hnd_ff;
   logic [TICK_W-1:0]   fire_rld_ff;
   logic                fire_per_ff;
   logic                pend_valid_ff, pend_valid_in;
   logic [HANDLE_W-1:0] pend_hnd_ff, pend_hnd_in;
   logic [CNT_W-1:0]    fire_cnt_ff, fire_cnt_in;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_fvalid_ff, out_fvalid_in;
   logic [HANDLE_W-1:0]   out_fhnd_ff, out_fhnd_in;
   logic                  out_active_ff, out_active_in;
   logic                  out_removed_ff, out_removed_in;
   logic                  out_full_ff, out_full_in;
   logic                  out_last_ff, out_last_in;

   logic             match_found;
   logic [IDX_W-1:0] match_idx;
   logic [IDX_W-1:0] ins_idx;
   logic [TICK_W-1:0] ins_tck;
   logic             full;
   logic             out_free;
   logic             fire_report;
   logic             do_remove, do_insert;
   logic [IDX_W-1:0] rm_idx;
   logic [HANDLE_W-1:0] ins_hnd;
   logic             ins_per, ins_seen;

   // first live entry holding the current handle
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (used_ff[i] && hnd_ff[i] == cur_hnd_ff) begin
            match_found = 1'b1;
            match_idx   = IDX_W'(i);
         end
      end
   end

   // insert source and position: before the first entry with more ticks
   always_comb begin
      if (cmd.op == TOP_INSERT_FIRED) begin
         ins_hnd  = fire_hnd_ff;
         ins_tck  = fire_rld_ff;
         ins_per  = 1'b1;
         ins_seen = 1'b1;
      end else begin
         ins_hnd  = cur_hnd_ff;
         ins_tck  = conv_ticks;
         ins_per  = cur_per_ff;
         ins_seen = 1'b0;
      end
      ins_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i] || ins_tck < tck_ff[i])
            ins_idx = IDX_W'(i);
      end
   end

   assign full        = used_ff[SLOTS-1];
   assign out_free    = !out_valid_ff || rsp_tready;
   assign fire_report = (hnd_ff[0] != '0) && (fire_cnt_ff < CNT_W'(MAX_RESULTS));

   assign status.out_free    = out_free;
   assign status.head_fire   = used_ff[0] && !seen_ff[0] && (tck_ff[0] == '0);
   assign status.fire_report = fire_report;
   assign status.pend_valid  = pend_valid_ff;

   // table operation select
   always_comb begin
      do_remove = 1'b0;
      do_insert = 1'b0;
      rm_idx    = '0;
      case (cmd.op)
         TOP_REMOVE_MATCH: begin
            do_remove = match_found;
            rm_idx    = match_idx;
         end
         TOP_FIRE_HEAD:    do_remove = 1'b1;
         TOP_INSERT_NEW:   do_insert = !full;
         TOP_INSERT_FIRED: do_insert = fire_per_ff && !full;
         default: ;
      endcase
   end

   // slot shifting, insertion and tick decrement
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         used_in[i] = used_ff[i];
         seen_in[i] = seen_ff[i];
         hnd_in[i]  = hnd_ff[i];
         tck_in[i]  = tck_ff[i];
         rld_in[i]  = rld_ff[i];
         per_in[i]  = per_ff[i];
         if (do_remove && IDX_W'(i) >= rm_idx) begin
            if (i < SLOTS - 1) begin
               used_in[i] = used_ff[(i + 1) % SLOTS];
               seen_in[i] = seen_ff[(i + 1) % SLOTS];
               hnd_in[i]  = hnd_ff[(i + 1) % SLOTS];
               tck_in[i]  = tck_ff[(i + 1) % SLOTS];
               rld_in[i]  = rld_ff[(i + 1) % SLOTS];
               per_in[i]  = per_ff[(i + 1) % SLOTS];
            end else begin
               used_in[i] = 1'b0;
               seen_in[i] = 1'b0;
            end
         end else if (do_insert && IDX_W'(i) == ins_idx) begin
            used_in[i] = 1'b1;
            seen_in[i] = ins_seen;
            hnd_in[i]  = ins_hnd;
            tck_in[i]  = ins_tck;
            rld_in[i]  = ins_tck;
            per_in[i]  = ins_per;
         end else if (do_insert && IDX_W'(i) > ins_idx && i > 0) begin
            used_in[i] = used_ff[(i + SLOTS - 1) % SLOTS];
            seen_in[i] = seen_ff[(i + SLOTS - 1) % SLOTS];
            hnd_in[i]  = hnd_ff[(i + SLOTS - 1) % SLOTS];
            tck_in[i]  = tck_ff[(i + SLOTS - 1) % SLOTS];
            rld_in[i]  = rld_ff[(i + SLOTS - 1) % SLOTS];
            per_in[i]  = per_ff[(i + SLOTS - 1) % SLOTS];
         end else if (cmd.op == TOP_TICK_DONE) begin
            if (used_ff[i] && !seen_ff[i])
               tck_in[i] = tck_ff[i] - 1'b1;
            seen_in[i] = 1'b0;
         end
      end
   end

   // pending firing and output register
   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_hnd_in    = pend_hnd_ff;
      fire_cnt_in    = fire_cnt_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_fvalid_in  = out_fvalid_ff;
      out_fhnd_in    = out_fhnd_ff;
      out_active_in  = out_active_ff;
      out_removed_in = out_removed_ff;
      out_full_in    = out_full_ff;
      out_last_in    = out_last_ff;
      if (cmd.capture) begin
         pend_valid_in = 1'b0;
         fire_cnt_in   = '0;
      end
      case (cmd.push)
         PUSH_ADD, PUSH_CANCEL, PUSH_QUERY: begin
            out_valid_in   = 1'b1;
            out_fvalid_in  = 1'b0;
            out_fhnd_in    = '0;
            out_active_in  = (cmd.push == PUSH_QUERY) && match_found;
            out_removed_in = (cmd.push == PUSH_CANCEL) && match_found;
            out_full_in    = (cmd.push == PUSH_ADD) && full;
            out_last_in    = 1'b1;
         end
         default: ;
      endcase
      if (cmd.op == TOP_FIRE_HEAD && fire_report) begin
         if (pend_valid_ff) begin
            out_valid_in   = 1'b1;
            out_fvalid_in  = 1'b1;
            out_fhnd_in    = pend_hnd_ff;
            out_active_in  = 1'b0;
            out_removed_in = 1'b0;
            out_full_in    = 1'b0;
            out_last_in    = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_hnd_in   = hnd_ff[0];
         fire_cnt_in   = fire_cnt_ff + 1'b1;
      end
      if (cmd.op == TOP_TICK_DONE) begin
         out_valid_in   = 1'b1;
         out_fvalid_in  = pend_valid_ff;
         out_fhnd_in    = pend_valid_ff ? pend_hnd_ff : '0;
         out_active_in  = 1'b0;
         out_removed_in = 1'b0;
         out_full_in    = 1'b0;
         out_last_in    = 1'b1;
         pend_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i] <= 1'b0;
            seen_ff[i] <= 1'b0;
         end
         pend_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i] <= used_in[i];
            seen_ff[i] <= seen_in[i];
         end
         pend_valid_ff <= pend_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
      for (int i = 0; i < SLOTS; i++) begin
         hnd_ff[i] <= hnd_in[i];
         tck_ff[i] <= tck_in[i];
         rld_ff[i] <= rld_in[i];
         per_ff[i] <= per_in[i];
      end
      if (cmd.capture) begin
         cur_hnd_ff <= req_handle;
         cur_per_ff <= req_periodic;
      end
      if (cmd.op == TOP_FIRE_HEAD) begin
         fire_hnd_ff <= hnd_ff[0];
         fire_rld_ff <= rld_ff[0];
         fire_per_ff <= per_ff[0];
      end
      pend_hnd_ff    <= pend_hnd_in;
      out_fvalid_ff  <= out_fvalid_in;
      out_fhnd_ff    <= out_fhnd_in;
      out_active_ff  <= out_active_in;
      out_removed_ff <= out_removed_in;
      out_full_ff    <= out_full_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0, out_full_ff, out_removed_ff, out_active_ff,
                        out_fhnd_ff, out_fvalid_ff};

endmodule

// File: design/stt_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted timer table controller
// Sequences add, cancel, query and the tick walk over the datapath.
// ----------------------------------------------------------------------------
module stt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  stt_pkg::action_type    req_action,
   input  logic                   conv_done,
   input  stt_pkg::status_type    status,
   output stt_pkg::cmd_type       cmd
);
   import stt_pkg::*;

   state_type state_ff, state_in;
   logic      accept;
   logic      fire_blocked;

   assign accept       = req_tvalid && req_tready;
   assign fire_blocked = status.fire_report && status.pend_valid && !status.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_ADD:    state_in = ST_ADD_RM;
                  ACT_CANCEL: state_in = ST_CANCEL;
                  ACT_QUERY:  state_in = ST_QUERY;
                  ACT_TICK:   state_in = ST_TICK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RM:   state_in = ST_ADD_WAIT;
         ST_ADD_WAIT: if (conv_done && status.out_free) state_in = ST_IDLE;
         ST_CANCEL:   if (status.out_free) state_in = ST_IDLE;
         ST_QUERY:    if (status.out_free) state_in = ST_IDLE;
         ST_TICK: begin
            if (status.head_fire) begin
               if (!fire_blocked) state_in = ST_REINS;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_REINS: state_in = ST_TICK;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = TOP_NONE;
      cmd.push    = PUSH_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = accept;
         end
         ST_ADD_RM: cmd.op = TOP_REMOVE_MATCH;
         ST_ADD_WAIT: begin
            if (conv_done && status.out_free) begin
               cmd.op   = TOP_INSERT_NEW;
               cmd.push = PUSH_ADD;
            end
         end
         ST_CANCEL: begin
            if (status.out_free) begin
               cmd.op   = TOP_REMOVE_MATCH;
               cmd.push = PUSH_CANCEL;
            end
         end
         ST_QUERY: if (status.out_free) cmd.push = PUSH_QUERY;
         ST_TICK: begin
            if (status.head_fire) begin
               if (!fire_blocked) cmd.op = TOP_FIRE_HEAD;
            end else if (status.out_free) begin
               cmd.op = TOP_TICK_DONE;
            end
         end
         ST_REINS: cmd.op = TOP_INSERT_FIRED;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/stt_checker.sv
// ----------------------------------------------------------------------------
// Sorted timer table checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
module stt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [stt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // one transaction in flight: ready drops after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a firing carries no other answer
   a_fire_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[17] && !rsp_tdata[18] && !rsp_tdata[19])
      else $error("fired result mixes fields");

   // handle zero expires silently
   a_fire_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[16:1] != 16'd0)
      else $error("firing reported for handle zero");

endmodule

bind sorted_timer_table_unit stt_checker u_stt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
